// ===== rtl/nnca_pkg.sv =====
// package for the node capacity allocator: sizes, codes and types
// no dependencies
package nnca_pkg;
  localparam int NODES = 4;
  localparam int REGIONS = 256;
  localparam int NW = 3;
  localparam int RW = 9;
  localparam int AW = 8;
  localparam int BW = 48;
  localparam logic [BW-1:0] DEFAULT_CAP = 48'h4_0000_0000;
  localparam logic [BW-1:0] MAX48 = {BW{1'b1}};

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  localparam logic [2:0] MODE_REQ   = 3'd0;
  localparam logic [2:0] MODE_PREF  = 3'd1;
  localparam logic [2:0] MODE_LOCAL = 3'd2;
  localparam logic [2:0] MODE_ILV   = 3'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOCAP   = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;

  localparam logic [2:0] CFG_ACTIVE = 3'd0;
  localparam logic [2:0] CFG_LOCAL  = 3'd1;
  localparam logic [2:0] CFG_CAP1   = 3'd2;
  localparam logic [2:0] CFG_CAP2   = 3'd3;
  localparam logic [2:0] CFG_CAP3   = 3'd4;
  localparam logic [2:0] CFG_CAP4   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_LOOK, S_SCAN, S_DIV, S_CHARGE, S_DONE
  } state_t;
endpackage

// ===== rtl/nnca_if.sv =====
// valid/ready channel interface carrying a generic payload
// depends on nothing
interface nnca_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/numa_node_capacity_allocator.sv =====
// Allocator for memory node capacity with a region table kept in a synchronous RAM.
// After reset a clearing pass runs over the region table; no item is
// taken then. Allocate in fixed modes runs a target check, one room check per node, then
// issue and charge; interleave runs a 48-step restoring divider by the set size, one
// issue step and four charge steps; free and probe do one table read, and free then
// writes the entry back as cleared.
// One item is in work at a time, and a new beat is taken only after the result beat
// has left the output register.
// depends on nnca_pkg and nnca_if
module numa_node_capacity_allocator import nnca_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  nnca_if.sink        in_ch,
  nnca_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  // input payload layout: operation, mode, req, bytes, mask, ref, hint
  logic [1:0]  i_op;
  logic [2:0]  i_mode, i_req, i_hint;
  logic [47:0] i_bytes;
  logic [3:0]  i_mask;
  logic [8:0]  i_ref;
  assign {i_op, i_mode, i_req, i_bytes, i_mask, i_ref, i_hint} = in_ch.data;

  logic [2:0]  active_r;
  logic [1:0]  local_r;
  logic [BW-1:0] cap_r [NODES];
  logic [BW-1:0] used_r [NODES];
  logic [RW-1:0] next_r;

  logic [2:0] tab [REGIONS];
  logic [2:0] tab_q;
  logic       tab_we;
  logic [AW-1:0] tab_wa, tab_ra;
  logic [2:0] tab_wd;

  state_t state_r;
  logic [1:0]  op_r;
  logic [2:0]  mode_r, req_r, hint_r;
  logic [47:0] bytes_r;
  logic [3:0]  set_r;
  logic [8:0]  ref_r;
  logic [1:0]  node_r;
  logic [2:0]  chosen_r;
  logic [2:0]  cnt_r;
  logic [5:0]  step_r;
  logic [47:0] quo_r;
  logic [2:0]  rem_r;
  logic [AW-1:0] clr_r;
  logic        ovalid_r;
  logic [13:0] odata_r;

  logic [2:0] act;
  assign act = (active_r == 3'd0) ? 3'd1 : (active_r > 3'd4 ? 3'd4 : active_r);

  logic [BW-1:0] room;
  assign room = (used_r[node_r] >= cap_r[node_r]) ? '0 : cap_r[node_r] - used_r[node_r];
  logic fits;
  assign fits = room >= bytes_r;

  logic [2:0] target;
  logic       has_t, fb;
  always_comb begin
    target = 3'd0; has_t = 1'b0; fb = 1'b1;
    if (mode_r == MODE_REQ || mode_r == MODE_PREF) begin
      target = req_r; has_t = req_r != 3'd0; fb = mode_r == MODE_PREF;
    end else if (mode_r == MODE_LOCAL) begin
      target = {1'b0, local_r} + 3'd1; has_t = 1'b1;
    end
  end

  logic [3:0] act_mask, eff_set;
  assign act_mask = (4'd1 << act) - 4'd1;
  assign eff_set = ((i_mask & act_mask) == 4'd0) ? act_mask : (i_mask & act_mask);
  logic [2:0] first_n;
  always_comb begin
    first_n = 3'd4;
    for (int k = 3; k >= 0; k--) if (eff_set[k]) first_n = 3'(k + 1);
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;

  always_ff @(posedge clk) begin
    if (tab_we) tab[tab_wa] <= tab_wd;
    tab_q <= tab[tab_ra];
  end
  assign tab_ra = 8'(i_ref - 9'd1);

  logic [3:0] rem_sh;
  assign rem_sh = {rem_r, quo_r[47]};

  always_comb begin
    tab_we = 1'b0; tab_wa = clr_r; tab_wd = 3'd0;
    if (state_r == S_CLEAR) tab_we = 1'b1;
    else if (state_r == S_LOOK && op_r == OP_FREE && ref_r >= 9'd1 && ref_r <= 9'd256
             && tab_q != 3'd0) begin
      tab_we = 1'b1; tab_wa = 8'(ref_r - 9'd1);
    end else if (state_r == S_CHARGE && step_r == 6'd0) begin
      tab_we = 1'b1; tab_wa = 8'(next_r - 9'd1); tab_wd = chosen_r;
    end
  end

  logic [48:0] sum;
  always_comb begin
    sum = {1'b0, used_r[node_r]} + {1'b0, (mode_r == MODE_ILV && op_r == OP_ALLOC)
          ? ((quo_r == '0) ? 48'd1 : quo_r) : bytes_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; ovalid_r <= 1'b0; next_r <= 9'd1;
      active_r <= 3'd4; local_r <= 2'd0;
      for (int k = 0; k < NODES; k++) begin
        cap_r[k] <= DEFAULT_CAP; used_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ACTIVE) active_r <= cfg_data[2:0];
        else if (cfg_index == CFG_LOCAL) local_r <= cfg_data[1:0];
        else if (cfg_index >= CFG_CAP1 && cfg_index <= CFG_CAP4)
          cap_r[2'(cfg_index - CFG_CAP1)] <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 8'd1;
          if (clr_r == 8'(REGIONS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          op_r <= i_op; mode_r <= i_mode; req_r <= i_req; bytes_r <= i_bytes;
          ref_r <= i_ref; hint_r <= i_hint; set_r <= eff_set;
          cnt_r <= 3'($countones(eff_set)); chosen_r <= 3'd0;
          if (i_op == OP_ALLOC) begin
            if (i_mode == MODE_ILV) begin
              quo_r <= i_bytes; rem_r <= '0; step_r <= '0; state_r <= S_DIV;
              chosen_r <= first_n;
            end else begin
              node_r <= '0; step_r <= '0; state_r <= S_SCAN;
            end
          end else if (i_op == OP_FREE || i_op == OP_PROBE) state_r <= S_LOOK;
          else begin
            odata_r <= '0; ovalid_r <= 1'b1;
          end
        end
        S_SCAN: begin
          // step 0 checks the target, then nodes 1..act in order
          if (step_r == 6'd0) begin
            if (has_t && target <= act) begin
              node_r <= 2'(target - 3'd1); step_r <= 6'd1;
            end else if (has_t && !fb) begin
              odata_r <= {ST_NOCAP, 9'd0, 3'd0}; ovalid_r <= 1'b1; state_r <= S_IDLE;
            end else begin
              node_r <= '0; step_r <= 6'd2;
            end
          end else if (step_r == 6'd1) begin
            if (fits) begin
              chosen_r <= {1'b0, node_r} + 3'd1; step_r <= '0; state_r <= S_CHARGE;
            end else if (!fb) begin
              odata_r <= {ST_NOCAP, 9'd0, 3'd0}; ovalid_r <= 1'b1; state_r <= S_IDLE;
            end else begin
              node_r <= '0; step_r <= 6'd2;
            end
          end else begin
            if (fits) begin
              chosen_r <= {1'b0, node_r} + 3'd1; step_r <= '0; state_r <= S_CHARGE;
            end else if ({1'b0, node_r} + 3'd1 >= act) begin
              odata_r <= {ST_NOCAP, 9'd0, 3'd0}; ovalid_r <= 1'b1; state_r <= S_IDLE;
            end else node_r <= node_r + 2'd1;
          end
        end
        S_DIV: begin
          // restoring division of bytes by the set size, one bit a cycle
          quo_r <= {quo_r[46:0], rem_sh >= {1'b0, cnt_r}};
          rem_r <= (rem_sh >= {1'b0, cnt_r}) ? 3'(rem_sh - {1'b0, cnt_r}) : rem_sh[2:0];
          step_r <= step_r + 6'd1;
          if (step_r == 6'd47) begin
            step_r <= '0; node_r <= '0; state_r <= S_CHARGE;
          end
        end
        S_CHARGE: begin
          // step 0 issues region; next steps charge nodes
          if (step_r == 6'd0) begin
            next_r <= (next_r >= 9'(REGIONS)) ? 9'd1 : next_r + 9'd1;
            odata_r <= {ST_OK, next_r, chosen_r};
            step_r <= 6'd1;
            if (mode_r != MODE_ILV) node_r <= 2'(chosen_r - 3'd1);
          end else begin
            if (mode_r != MODE_ILV || set_r[node_r])
              used_r[node_r] <= sum[48] ? MAX48 : sum[47:0];
            if (mode_r != MODE_ILV || node_r == 2'd3) begin
              ovalid_r <= 1'b1; state_r <= S_IDLE;
            end else node_r <= node_r + 2'd1;
          end
        end
        S_LOOK: begin
          if (ref_r == 9'd0 || ref_r > 9'd256 || tab_q == 3'd0)
            odata_r <= {ST_NOTFND, 9'd0, (op_r == OP_PROBE) ? hint_r : 3'd0};
          else begin
            odata_r <= {ST_OK, 9'd0, tab_q};
            if (op_r == OP_FREE)
              used_r[2'(tab_q - 3'd1)] <= (bytes_r >= used_r[2'(tab_q - 3'd1)]) ? '0
                : used_r[2'(tab_q - 3'd1)] - bytes_r;
          end
          ovalid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/nnca_checker.sv =====
// port-level checks for the allocator, bound to the top level
// depends on nnca_pkg
module nnca_checker import nnca_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("beat dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data[13:12] != 2'd3) else $error("bad status");
  a_nocap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[13:12] == ST_NOCAP |-> out_data[11:0] == 12'd0)
    else $error("nocap with payload");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
endmodule

bind numa_node_capacity_allocator nnca_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
